// ===== rtl/core/arm_rel_addend_decoder_macros.svh =====
// assertion macros used by the relocation addend decoder rtl
`ifndef ARM_REL_ADDEND_DECODER_MACROS_SVH
`define ARM_REL_ADDEND_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked at every rising edge out of reset
`define ARD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ARD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ARD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ARD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ardec_pkg.sv =====
// types and constants of the relocation addend decoder
package ardec_pkg;

    localparam int MAX_SYMBOLS_DEF = 65536;
    localparam int COUNT_W         = 17;

    // relocation type numbers
    localparam logic [7:0] R_NONE        = 8'd0;
    localparam logic [7:0] R_ABS32       = 8'd2;
    localparam logic [7:0] R_REL32       = 8'd3;
    localparam logic [7:0] R_THM_CALL    = 8'd10;
    localparam logic [7:0] R_CALL        = 8'd28;
    localparam logic [7:0] R_JUMP24      = 8'd29;
    localparam logic [7:0] R_TARGET1     = 8'd38;
    localparam logic [7:0] R_V4BX        = 8'd40;
    localparam logic [7:0] R_TARGET2     = 8'd41;
    localparam logic [7:0] R_PREL31      = 8'd42;
    localparam logic [7:0] R_MOVW_ABS    = 8'd43;
    localparam logic [7:0] R_MOVT_ABS    = 8'd44;
    localparam logic [7:0] R_THM_MOVW    = 8'd47;
    localparam logic [7:0] R_THM_MOVT    = 8'd48;

    typedef enum logic [3:0] {
        ST_READY          = 4'd0,
        ST_IGNORED        = 4'd1,
        ST_HELD           = 4'd2,
        ST_WRONG_FOLLOWER = 4'd3,
        ST_UNEXPECTED     = 4'd4,
        ST_INVALID        = 4'd5,
        ST_SYM_RANGE      = 4'd6,
        ST_PAIR_SYM       = 4'd7,
        ST_NOT_ADJ        = 4'd8,
        ST_UNPAIRED       = 4'd9
    } t_status;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'b001,
        KIND_ARM   = 3'b010,
        KIND_THUMB = 3'b100
    } t_kind;

    typedef enum logic [2:0] {
        C_IGNORE,
        C_NORMAL,
        C_LOW,
        C_HIGH,
        C_BAD
    } t_cls;

    typedef struct packed {
        logic [7:0]  reloc_type;
        logic [31:0] reloc_offset;
        logic [15:0] symbol_index;
        logic [31:0] symbol_value;
        logic [31:0] instruction_word;
        logic        last_in_table;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] addend;
        logic        also_for_previous;
    } t_out_item;

    typedef struct packed {
        t_cls        cls;
        logic [31:0] target;
    } t_dec;

endpackage

// ===== rtl/core/ardec_target.sv =====
// relocation type classification and implicit target decode
module ardec_target (
    input  ardec_pkg::t_in_item i_item,
    output ardec_pkg::t_dec     o_dec
);
    import ardec_pkg::*;

    logic [31:0] w_word;
    logic [31:0] w_off;
    logic [15:0] w_arm_imm;
    logic [15:0] w_thm_imm;
    logic [22:0] w_bl_imm;

    assign w_word    = i_item.instruction_word;
    assign w_off     = i_item.reloc_offset;
    assign w_arm_imm = {w_word[19:16], w_word[11:0]};
    // thumb halves arrive swapped: first halfword sits in the low 16 bits
    assign w_thm_imm = {w_word[3:0], w_word[10], w_word[30:28], w_word[23:16]};
    assign w_bl_imm  = {w_word[10:0], w_word[26:16], 1'b0};

    always_comb begin
        o_dec.cls    = C_BAD;
        o_dec.target = '0;
        unique case (i_item.reloc_type)
            R_NONE, R_V4BX: begin
                o_dec.cls = C_IGNORE;
            end
            R_ABS32, R_TARGET1: begin
                o_dec.cls    = C_NORMAL;
                o_dec.target = w_word;
            end
            R_REL32, R_TARGET2, R_PREL31: begin
                o_dec.cls    = C_NORMAL;
                o_dec.target = w_word + w_off;
            end
            R_THM_CALL: begin
                o_dec.cls    = C_NORMAL;
                o_dec.target = 32'(w_bl_imm) + w_off + 32'd4;
            end
            R_CALL, R_JUMP24: begin
                o_dec.cls    = C_NORMAL;
                o_dec.target = {w_word[29:0] & 30'h00ffffff, 2'b00} + w_off;
            end
            R_MOVW_ABS: begin
                o_dec.cls    = C_LOW;
                o_dec.target = {16'h0000, w_arm_imm};
            end
            R_MOVT_ABS: begin
                o_dec.cls    = C_HIGH;
                o_dec.target = {w_arm_imm, 16'h0000};
            end
            R_THM_MOVW: begin
                o_dec.cls    = C_LOW;
                o_dec.target = {16'h0000, w_thm_imm};
            end
            R_THM_MOVT: begin
                o_dec.cls    = C_HIGH;
                o_dec.target = {w_thm_imm, 16'h0000};
            end
            default: begin
                o_dec.cls    = C_BAD;
                o_dec.target = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/ardec_pair.sv =====
// movw/movt pairing state, status selection and addend subtraction
`include "arm_rel_addend_decoder_macros.svh"

module ardec_pair #(
    parameter int MAX_SYMBOLS = ardec_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [ardec_pkg::COUNT_W-1:0] i_symbol_count,
    input  ardec_pkg::t_in_item         i_item,
    input  ardec_pkg::t_dec             i_dec,
    output ardec_pkg::t_out_item        o_res
);
    import ardec_pkg::*;

    localparam int LW = $clog2(MAX_SYMBOLS + 1);
    localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;

    t_kind       r_pending, n_pending;
    logic [15:0] r_held_symbol, n_held_symbol;
    logic [31:0] r_held_offset, n_held_offset;
    logic [31:0] r_partial, n_partial;

    logic [CW-1:0] w_count, w_max, w_limit, w_sym;
    logic [7:0]    w_expected;
    logic          w_use_partial;
    logic          w_do_sub;
    logic          w_both;
    t_status       w_status;
    logic [31:0]   w_sub_target;
    logic [31:0]   w_diff;

    assign w_count    = CW'(i_symbol_count);
    assign w_max      = CW'(MAX_SYMBOLS);
    assign w_limit    = (w_count < w_max) ? w_count : w_max;
    assign w_sym      = CW'(i_item.symbol_index);
    assign w_expected = (r_pending == KIND_ARM) ? R_MOVT_ABS : R_THM_MOVT;

    always_comb begin
        n_pending     = r_pending;
        n_held_symbol = r_held_symbol;
        n_held_offset = r_held_offset;
        n_partial     = r_partial;
        w_status      = ST_READY;
        w_use_partial = 1'b0;
        w_do_sub      = 1'b0;
        w_both        = 1'b0;
        priority if (r_pending != KIND_NONE && i_item.reloc_type != w_expected) begin
            w_status  = ST_WRONG_FOLLOWER;
            n_pending = KIND_NONE;
        end else if (i_dec.cls == C_IGNORE) begin
            w_status = ST_IGNORED;
        end else if (i_dec.cls == C_HIGH && r_pending == KIND_NONE) begin
            w_status = ST_UNEXPECTED;
        end else if (i_dec.cls == C_BAD) begin
            w_status = ST_INVALID;
        end else if (w_sym >= w_limit) begin
            w_status  = ST_SYM_RANGE;
            n_pending = KIND_NONE;
        end else if (i_dec.cls == C_HIGH) begin
            n_pending = KIND_NONE;
            priority if (i_item.symbol_index != r_held_symbol) begin
                w_status = ST_PAIR_SYM;
            end else if (i_item.reloc_offset != r_held_offset + 32'd4) begin
                w_status = ST_NOT_ADJ;
            end else begin
                w_use_partial = 1'b1;
                w_do_sub      = 1'b1;
                w_both        = 1'b1;
            end
        end else if (i_dec.cls == C_LOW) begin
            if (i_item.reloc_type == R_MOVW_ABS) begin
                n_pending = KIND_ARM;
            end else begin
                n_pending = KIND_THUMB;
            end
            n_held_symbol = i_item.symbol_index;
            n_held_offset = i_item.reloc_offset;
            n_partial     = i_dec.target;
            w_status      = ST_HELD;
        end else begin
            w_do_sub = 1'b1;
        end

        // a movw at the end of the table can never be paired
        if (i_item.last_in_table && n_pending != KIND_NONE) begin
            w_status  = ST_UNPAIRED;
            n_pending = KIND_NONE;
            w_do_sub  = 1'b0;
            w_both    = 1'b0;
        end
    end

    assign w_sub_target = w_use_partial ? (r_partial | i_dec.target) : i_dec.target;
    assign w_diff       = w_sub_target - i_item.symbol_value;

    assign o_res.status            = w_status;
    assign o_res.addend            = w_do_sub ? w_diff : 32'd0;
    assign o_res.also_for_previous = w_both;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= KIND_NONE;
        end else if (i_en) begin
            r_pending <= n_pending;
        end
    end

    // held fields are only read while a pair is pending
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_held_symbol <= n_held_symbol;
            r_held_offset <= n_held_offset;
            r_partial     <= n_partial;
        end
    end

    `ARD_ASSERT_NEXT(a_held_sets_pending, i_clk, i_rst_n,
        i_en && w_status == ST_HELD, r_pending != KIND_NONE)
    `ARD_ASSERT_NOW(a_pair_needs_pending, i_clk, i_rst_n,
        i_en && w_both, r_pending != KIND_NONE && i_dec.cls == C_HIGH)
    `ARD_ASSERT_NEXT(a_last_clears_pending, i_clk, i_rst_n,
        i_en && i_item.last_in_table, r_pending == KIND_NONE)
    `ARD_ASSERT_NOW(a_addend_zero_on_error, i_clk, i_rst_n,
        i_en && w_status != ST_READY, o_res.addend == 32'd0 && !w_both)

endmodule

// ===== rtl/core/arm_rel_addend_decoder.sv =====
// ARM REL relocation addend decoder, top level
// One relocation enters per cycle while the result side does not stall; the item is
// captured in an input register, decoded and paired in one pass of logic, and the result
// is held in an output register. Throughput is one item per clock under that condition;
// a stall on the result side backs up through both registers. A movw answers with status
// held and its movt carries the combined addend with also_for_previous set. symbol_count
// is written through the configuration channel, which is always ready; the user must
// write it only while no relocation is in flight, which the block itself does not enforce.
module arm_rel_addend_decoder #(
    parameter int MAX_SYMBOLS = ardec_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ardec_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ardec_pkg::t_out_item          o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ardec_pkg::COUNT_W-1:0] i_cfg_data
);
    import ardec_pkg::*;

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [COUNT_W-1:0] r_symbol_count;

    logic      w_adv;
    logic      w_step;
    t_dec      w_dec;
    t_out_item w_res;

    // result register frees up when empty or when its transaction completes
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    ardec_target u_target (
        .i_item (r_in),
        .o_dec  (w_dec)
    );

    ardec_pair #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_pair (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_step),
        .i_symbol_count (r_symbol_count),
        .i_item         (r_in),
        .i_dec          (w_dec),
        .o_res          (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_symbol_count <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_valid) begin
                r_symbol_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

endmodule

// ===== verif/arm_rel_addend_decoder_test.sv =====
// self-checking testbench for the arm rel relocation addend decoder
`timescale 1ns / 100ps

module arm_rel_addend_decoder_test;

    import ardec_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_PRINTS  = 40;
    localparam logic [16:0] SYMBOL_CAP = 17'(MAX_SYMBOLS_DEF);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_data = '0;

    // predictor state: loaded symbol count and the held movw
    logic [16:0]  sym_count_model = '0;
    t_kind        pair_kind = KIND_NONE;
    logic [15:0]  pair_symbol = '0;
    logic [31:0]  pair_offset = '0;
    logic [31:0]  pair_low_target = '0;

    t_in_item     pending_relocs[$];
    t_out_item    expected_results[$];

    int mismatch_count = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    int stall_tick = 0;
    int stall_mode = 0;
    t_out_item want;

    arm_rel_addend_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_cls reloc_class(logic [7:0] t);
        case (t)
            R_NONE, R_V4BX: return C_IGNORE;
            R_ABS32, R_TARGET1, R_REL32, R_TARGET2, R_PREL31,
            R_THM_CALL, R_CALL, R_JUMP24: return C_NORMAL;
            R_MOVW_ABS, R_THM_MOVW: return C_LOW;
            R_MOVT_ABS, R_THM_MOVT: return C_HIGH;
            default: return C_BAD;
        endcase
    endfunction

    function automatic logic [31:0] implicit_target(logic [7:0] t, logic [31:0] w,
                                                    logic [31:0] p);
        logic [31:0] sw;
        logic [15:0] arm_imm;
        logic [15:0] thumb_imm;
        sw = {w[15:0], w[31:16]};
        arm_imm = {w[19:16], w[11:0]};
        thumb_imm = {sw[19:16], sw[26], sw[14:12], sw[7:0]};
        case (t)
            R_ABS32, R_TARGET1: return w;
            R_REL32, R_TARGET2, R_PREL31: return w + p;
            R_THM_CALL: return {9'b0, sw[26:16], sw[10:0], 1'b0} + p + 32'd4;
            R_CALL, R_JUMP24: return {6'b0, w[23:0], 2'b00} + p;
            R_MOVW_ABS: return {16'b0, arm_imm};
            R_MOVT_ABS: return {arm_imm, 16'b0};
            R_THM_MOVW: return {16'b0, thumb_imm};
            R_THM_MOVT: return {thumb_imm, 16'b0};
            default: return 32'b0;
        endcase
    endfunction

    // one result per relocation; updates the movw/movt pairing state
    function automatic t_out_item resolve_addend(t_in_item r);
        t_out_item   res;
        t_status     st;
        t_cls        cls;
        logic [16:0] limit;
        logic [7:0]  follower;
        st = ST_READY;
        res = '0;
        cls = reloc_class(r.reloc_type);
        limit = (sym_count_model < SYMBOL_CAP) ? sym_count_model : SYMBOL_CAP;
        follower = (pair_kind == KIND_ARM) ? R_MOVT_ABS : R_THM_MOVT;
        if (pair_kind != KIND_NONE && r.reloc_type != follower) begin
            st = ST_WRONG_FOLLOWER;
            pair_kind = KIND_NONE;
        end else if (cls == C_IGNORE) begin
            st = ST_IGNORED;
        end else if (cls == C_HIGH && pair_kind == KIND_NONE) begin
            st = ST_UNEXPECTED;
        end else if (cls == C_BAD) begin
            st = ST_INVALID;
        end else if ({1'b0, r.symbol_index} >= limit) begin
            st = ST_SYM_RANGE;
            pair_kind = KIND_NONE;
        end else if (cls == C_HIGH) begin
            pair_kind = KIND_NONE;
            if (r.symbol_index != pair_symbol) begin
                st = ST_PAIR_SYM;
            end else if (r.reloc_offset != pair_offset + 32'd4) begin
                st = ST_NOT_ADJ;
            end else begin
                res.addend = (pair_low_target |
                              implicit_target(r.reloc_type, r.instruction_word,
                                              r.reloc_offset)) - r.symbol_value;
                res.also_for_previous = 1'b1;
            end
        end else if (cls == C_LOW) begin
            if (r.reloc_type == R_MOVW_ABS) begin
                pair_kind = KIND_ARM;
            end else begin
                pair_kind = KIND_THUMB;
            end
            pair_symbol = r.symbol_index;
            pair_offset = r.reloc_offset;
            pair_low_target = implicit_target(r.reloc_type, r.instruction_word,
                                              r.reloc_offset);
            st = ST_HELD;
        end else begin
            res.addend = implicit_target(r.reloc_type, r.instruction_word, r.reloc_offset)
                         - r.symbol_value;
        end
        // a movw left open at the end of the table
        if (r.last_in_table && pair_kind != KIND_NONE) begin
            st = ST_UNPAIRED;
            pair_kind = KIND_NONE;
            res.addend = '0;
            res.also_for_previous = 1'b0;
        end
        res.status = st;
        return res;
    endfunction

    function automatic t_in_item make_reloc(logic [7:0] t, logic [31:0] off, logic [15:0] sym,
                                            logic [31:0] val, logic [31:0] w, logic last);
        t_in_item r;
        r.reloc_type = t;
        r.reloc_offset = off;
        r.symbol_index = sym;
        r.symbol_value = val;
        r.instruction_word = w;
        r.last_in_table = last;
        return r;
    endfunction

    function automatic logic [7:0] normal_type(int k);
        case (k)
            0: return R_ABS32;
            1: return R_TARGET1;
            2: return R_REL32;
            3: return R_TARGET2;
            4: return R_PREL31;
            5: return R_THM_CALL;
            6: return R_CALL;
            default: return R_JUMP24;
        endcase
    endfunction

    function automatic logic [15:0] pick_symbol(int limit);
        if (limit == 0 || $urandom_range(0, 9) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, limit - 1));
    endfunction

    function automatic logic closes_table();
        return $urandom_range(0, 24) == 0;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: %s mismatch: got %h, want %h", $time, what, got, wanted);
        mismatch_count++;
    endtask

    task automatic write_symbol_count(logic [16:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sym_count_model = value;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_relocs.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    // mostly normal items and well formed movw/movt pairs, mixed with broken pairs and noise
    task automatic queue_random_relocs(int count, int limit);
        int          made;
        int          pick;
        logic [7:0]  t_lo;
        logic [7:0]  t_hi;
        logic [31:0] off;
        logic [15:0] sym;
        logic [15:0] flip;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            off = $urandom;
            sym = pick_symbol(limit);
            t_lo = $urandom_range(0, 1) ? R_MOVW_ABS : R_THM_MOVW;
            t_hi = (t_lo == R_MOVW_ABS) ? R_MOVT_ABS : R_THM_MOVT;
            if (pick < 35) begin
                pending_relocs.push_back(make_reloc(normal_type($urandom_range(0, 7)), off,
                                                    sym, $urandom, $urandom, closes_table()));
                made += 1;
            end else if (pick < 65) begin
                pending_relocs.push_back(make_reloc(t_lo, off, sym, $urandom, $urandom, 1'b0));
                pending_relocs.push_back(make_reloc(t_hi, off + 32'd4, sym, $urandom, $urandom,
                                                    closes_table()));
                made += 2;
            end else if (pick < 80) begin
                pending_relocs.push_back(make_reloc(t_lo, off, sym, $urandom, $urandom,
                                                    $urandom_range(0, 5) == 0));
                flip = 16'($urandom_range(1, 65535));
                case ($urandom_range(0, 3))
                    0: pending_relocs.push_back(make_reloc(8'($urandom_range(0, 255)),
                                                           off + 32'd4,
                                                           sym, $urandom, $urandom, 1'b0));
                    1: pending_relocs.push_back(make_reloc(t_hi, off + 32'd4, sym ^ flip,
                                                           $urandom, $urandom, 1'b0));
                    2: pending_relocs.push_back(make_reloc(t_hi,
                                                           off + 32'd4 + $urandom_range(1, 64),
                                                           sym, $urandom, $urandom, 1'b0));
                    default: pending_relocs.push_back(make_reloc(t_hi, off + 32'd4,
                                                                 pick_symbol(limit), $urandom,
                                                                 $urandom, 1'b0));
                endcase
                made += 2;
            end else if (pick < 88) begin
                pending_relocs.push_back(make_reloc(t_hi, off, sym, $urandom, $urandom,
                                                    closes_table()));
                made += 1;
            end else if (pick < 94) begin
                // ignored types, not counted
                pending_relocs.push_back(make_reloc($urandom_range(0, 1) ? R_NONE : R_V4BX, off,
                                                    sym, $urandom, $urandom, closes_table()));
            end else begin
                pending_relocs.push_back(make_reloc(8'($urandom_range(0, 255)), off, sym,
                                                    $urandom, $urandom, closes_table()));
                made += 1;
            end
        end
    endtask

    task automatic run_phase(logic [16:0] count, int items);
        write_symbol_count(count);
        queue_random_relocs(items, (count > SYMBOL_CAP) ? int'(SYMBOL_CAP) : int'(count));
        wait_idle();
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(resolve_addend(i_in_data));
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_relocs.size() != 0) begin
                    i_in_data <= pending_relocs.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                                 : $urandom_range(1, 10);
                        gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result transaction and stalls on a pattern of its own
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            quiet_cycles = 0;
        end else begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, addend", o_out_data.addend, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
                    if (o_out_data.addend !== want.addend)
                        report_mismatch("addend", o_out_data.addend, want.addend);
                    if (o_out_data.also_for_previous !== want.also_for_previous)
                        report_mismatch("also_for_previous",
                                        32'(o_out_data.also_for_previous),
                                        32'(want.also_for_previous));
                end
                // long hold-off so the pipeline fills and stalls the sender
                if (results_seen % 700 == 300)
                    hold_left = HOLD_CYCLES;
            end
            stall_tick++;
            if (stall_tick % 150 == 0)
                stall_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= stall_tick[0];
                endcase
            end
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every type, field extremes and the pairing special cases, all symbols loaded
        write_symbol_count(SYMBOL_CAP);
        pending_relocs.push_back(make_reloc(R_ABS32, 32'h0, 16'h0, 32'h0, 32'hFFFFFFFF, 1'b0));
        pending_relocs.push_back(make_reloc(R_TARGET1, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF,
                                            32'h0, 1'b0));
        pending_relocs.push_back(make_reloc(R_REL32, 32'h80000000, 16'h1, 32'h1, 32'h80000000,
                                            1'b0));
        pending_relocs.push_back(make_reloc(R_TARGET2, 32'h1234, 16'h2, 32'h0, 32'hFFFFFFFF,
                                            1'b0));
        pending_relocs.push_back(make_reloc(R_PREL31, 32'hFFFFFFFC, 16'h3, 32'h10, 32'h7FFFFFFF,
                                            1'b0));
        pending_relocs.push_back(make_reloc(R_THM_CALL, 32'hFFFFFFF0, 16'h4, 32'h0,
                                            32'hFFFFFFFF, 1'b0));
        pending_relocs.push_back(make_reloc(R_CALL, 32'h100, 16'h5, 32'h0, 32'h00FFFFFF, 1'b0));
        pending_relocs.push_back(make_reloc(R_JUMP24, 32'hFFFFFF00, 16'h5, 32'h4, 32'hFF000000,
                                            1'b0));
        pending_relocs.push_back(make_reloc(R_NONE, 32'h200, 16'h6, 32'h0, 32'h0, 1'b0));
        pending_relocs.push_back(make_reloc(R_V4BX, 32'h204, 16'h6, 32'h0, 32'h0, 1'b1));
        // arm pair closed by the last entry of the table
        pending_relocs.push_back(make_reloc(R_MOVW_ABS, 32'h1000, 16'hFFFF, 32'h0,
                                            32'h000F0FFF, 1'b0));
        pending_relocs.push_back(make_reloc(R_MOVT_ABS, 32'h1004, 16'hFFFF, 32'h12345678,
                                            32'hFFFFFFFF, 1'b1));
        // thumb pair whose offset wraps around
        pending_relocs.push_back(make_reloc(R_THM_MOVW, 32'hFFFFFFFC, 16'h7, 32'h0,
                                            32'hFFFFFFFF, 1'b0));
        pending_relocs.push_back(make_reloc(R_THM_MOVT, 32'h0, 16'h7, 32'h1, 32'hFFFFFFFF,
                                            1'b0));
        pending_relocs.push_back(make_reloc(R_MOVT_ABS, 32'h2000, 16'h8, 32'h0, 32'h0F0F0F0F,
                                            1'b0));
        pending_relocs.push_back(make_reloc(8'hFF, 32'h2004, 16'h8, 32'h0, 32'h0, 1'b0));
        pending_relocs.push_back(make_reloc(8'd1, 32'h2008, 16'h8, 32'h0, 32'h0, 1'b0));
        // wrong follower (ignored type, other movt kind), pair mismatches, unpaired movw
        pending_relocs.push_back(make_reloc(R_MOVW_ABS, 32'h3000, 16'h9, 32'h0, 32'h1, 1'b0));
        pending_relocs.push_back(make_reloc(R_NONE, 32'h3004, 16'h9, 32'h0, 32'h0, 1'b0));
        pending_relocs.push_back(make_reloc(R_THM_MOVW, 32'h3100, 16'h9, 32'h0, 32'h1, 1'b0));
        pending_relocs.push_back(make_reloc(R_MOVT_ABS, 32'h3104, 16'h9, 32'h0, 32'h1, 1'b0));
        pending_relocs.push_back(make_reloc(R_MOVW_ABS, 32'h3200, 16'h5, 32'h0, 32'h1, 1'b0));
        pending_relocs.push_back(make_reloc(R_MOVT_ABS, 32'h3204, 16'h6, 32'h0, 32'h1, 1'b0));
        pending_relocs.push_back(make_reloc(R_THM_MOVW, 32'h100, 16'h5, 32'h0, 32'h1, 1'b0));
        pending_relocs.push_back(make_reloc(R_THM_MOVT, 32'h108, 16'h5, 32'h0, 32'h1, 1'b0));
        pending_relocs.push_back(make_reloc(R_MOVW_ABS, 32'h4000, 16'h5, 32'h0, 32'h1, 1'b1));
        wait_idle();

        // no symbols loaded: everything that names one is out of range
        run_phase(17'd0, 40);

        // symbol range check on a movt clears the pending pair
        write_symbol_count(17'd16);
        pending_relocs.push_back(make_reloc(R_MOVW_ABS, 32'h500, 16'd3, 32'h0, 32'h1, 1'b0));
        pending_relocs.push_back(make_reloc(R_MOVT_ABS, 32'h504, 16'd16, 32'h0, 32'h1, 1'b0));
        pending_relocs.push_back(make_reloc(R_MOVT_ABS, 32'h504, 16'd3, 32'h0, 32'h1, 1'b0));
        queue_random_relocs(200, 16);
        wait_idle();

        run_phase(17'd1, 150);
        run_phase(SYMBOL_CAP, 270);
        run_phase(17'($urandom_range(2, 65535)), 300);
        run_phase(17'd300, 300);
        run_phase(17'd65535, 200);

        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ardec_pkg.sv
rtl/core/ardec_target.sv
rtl/core/ardec_pair.sv
rtl/core/arm_rel_addend_decoder.sv
verif/arm_rel_addend_decoder_test.sv
